@@ design/hbbrm_pkg.sv @@
// Shared types, codes and constants of the hole block bitmap range marker.
// No dependencies; used by the top level of the block and by its checker.
package hbbrm_pkg;

   // Defaults of the top-level parameters
   localparam int BLOCK_SHIFT_DEF    = 20;
   localparam int BLOCKS_PER_MAP_DEF = 65536;

   // Field widths
   localparam int SHIFT_W    = 5;
   localparam int OP_W       = 2;
   localparam int SEL_W      = 2;
   localparam int PAGE_W     = 31;
   localparam int BYTE_OUT_W = 51;
   localparam int BYTE_W     = 52;   // internal byte arithmetic, one guard bit
   localparam int WORD_BITS  = 64;   // bitmap word
   localparam int WOFF_W     = 6;    // bit offset inside a word

   // Port widths
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 168;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_INDEX_W = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_PAGE_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOB_PAGE_SHIFT  = 2'd1;

   // Page shift ranges and reset values
   localparam logic [SHIFT_W-1:0] DATA_SHIFT_MIN = 5'd12;
   localparam logic [SHIFT_W-1:0] DATA_SHIFT_MAX = 5'd16;
   localparam logic [SHIFT_W-1:0] DATA_SHIFT_RST = 5'd16;
   localparam logic [SHIFT_W-1:0] LOB_SHIFT_MIN  = 5'd12;
   localparam logic [SHIFT_W-1:0] LOB_SHIFT_MAX  = 5'd19;
   localparam logic [SHIFT_W-1:0] LOB_SHIFT_RST  = 5'd18;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_RESET = 2'd2
   } op_type;

   typedef enum logic [SEL_W-1:0] {
      MAP_DATA  = 2'd0,
      MAP_INDEX = 2'd1,
      MAP_LOB   = 2'd2
   } map_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CALC_SHIFT,
      ST_CALC_ALIGN,
      ST_CALC_COUNT,
      ST_CALC_END,
      ST_RANGE,
      ST_READ,
      ST_WRITE,
      ST_OUTPUT
   } state_type;

   function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] v,
                                                      input logic [SHIFT_W-1:0] lo,
                                                      input logic [SHIFT_W-1:0] hi);
      logic [SHIFT_W-1:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage

@@ design/hbbrm_mem.sv @@
// Bitmap word memory: one write port, one read port, registered read data.
// Depends on nothing; sized by its parameters.
module hbbrm_mem #(
   parameter int DEPTH  = 3072,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data registered when rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hole_block_bitmap_range_marker.sv @@
// Top level of the hole block bitmap range marker: request sequencer, range
// arithmetic and read-modify-write walk. Uses hbbrm_pkg and hbbrm_mem.
//
// Usage
//  - csr_*: register writes (index 0 data/index page shift, 1 large object page
//    shift), always ready; write only while no request is in flight.
//  - req_*: one transaction per request (op, map_select, start_page, num_pages).
//  - rsp_*: exactly one result transaction per request, in request order.
// Sequence
//  - Set and clear: range arithmetic in the shift, align, count, end and range
//    steps, then a read step and a modify-and-write-back step per bitmap word
//    covered (through the single memory port pair), then the result register is
//    loaded. No words are walked when the aligned range is empty or past
//    capacity; the next request is taken once the result is loaded.
//  - Reset of a map: a read and a write-back of each of the WORDS words
//    (WORDS = BLOCKS_PER_MAP/64 rounded up).
//  - Unknown op or map: straight to the result, all zero.
// Reset
//  - After reset a clearing pass writes all 3*WORDS memory words to zero
//    (3072 at the defaults); req_tready stays low meanwhile.
// Stalls
//  - The result sits in an output register; the next request is accepted
//    while it waits, and that request holds in its last step until rsp_tready.
module hole_block_bitmap_range_marker #(
   parameter int BLOCK_SHIFT    = hbbrm_pkg::BLOCK_SHIFT_DEF,
   parameter int BLOCKS_PER_MAP = hbbrm_pkg::BLOCKS_PER_MAP_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hbbrm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hbbrm_pkg::SHIFT_W-1:0]       csr_data,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [30:0] start_page, [61:31] num_pages, [63:62] zero
   input  logic [hbbrm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] op, [3:2] map_select
   input  logic [hbbrm_pkg::REQ_USER_W-1:0]    req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [30:0] adj_start_page, [61:31] adj_num_pages, [112:62] byte_offset,
   // [163:113] byte_length, [167:164] zero
   output logic [hbbrm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] changed, [1] offset_valid
   output logic [hbbrm_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import hbbrm_pkg::*;

   localparam int WORDS  = (BLOCKS_PER_MAP + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W  = $clog2(BLOCKS_PER_MAP);
   localparam int DEPTH  = 3 * WORDS;
   localparam int MA_W   = $clog2(DEPTH);
   localparam int BLK_W  = BYTE_W - BLOCK_SHIFT;

   localparam logic [BYTE_W-1:0] BLK_SIZE = BYTE_W'(1) << BLOCK_SHIFT;
   localparam logic [BYTE_W-1:0] BLK_MASK = BLK_SIZE - BYTE_W'(1);
   localparam logic [BLK_W-1:0]  BLK_CAP  = BLK_W'(BLOCKS_PER_MAP);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);
   localparam logic [MA_W-1:0]   LAST_ADDR = MA_W'(DEPTH - 1);
   localparam logic [WORD_BITS-1:0] ONES  = {WORD_BITS{1'b1}};

   // control state
   state_type state_ff, state_in;
   logic [MA_W-1:0] clr_addr_ff;
   logic [SHIFT_W-1:0] data_shift_ff, lob_shift_ff;
   logic rsp_tvalid_ff;

   // request registers
   op_type op_ff;
   logic req_ok_ff;
   logic set_bits_ff;
   logic [PAGE_W-1:0] start_ff, num_ff;
   logic [SHIFT_W-1:0] ps_ff;

   // range arithmetic
   logic [BYTE_W-1:0] offset_ff, length_ff;
   logic [BLK_W-1:0] bstart_ff, cnt_ff, hi_ff;
   logic [PAGE_W-1:0] res_start_ff, res_num_ff;
   logic [BYTE_OUT_W-1:0] res_boff_ff, res_blen_ff;

   // word walk
   logic [MA_W-1:0] base_ff;
   logic [WORD_W-1:0] word_ff, first_word_ff, last_word_ff;
   logic [WOFF_W-1:0] lo_off_ff, hi_off_ff;
   logic [WORD_BITS-1:0] mask_ff;
   logic chg_ff;

   // output register
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_USER_W-1:0] rsp_tuser_ff;

   // combinational
   logic req_fire, rsp_load, walk_done;
   op_type req_op;
   logic [SEL_W-1:0] req_sel;
   logic req_ok;
   logic [MA_W-1:0] word_addr;
   logic mem_wr_en, mem_rd_en;
   logic [MA_W-1:0] mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data, new_word;
   logic [BYTE_W-1:0] rem, cut, astart, acnt;
   logic [BLK_W-1:0] bstart0, bend, hi_last;
   logic [IDX_W-1:0] lo_idx, hi_idx;
   logic [WORD_BITS-1:0] lo_part, hi_part;
   logic offset_valid;

   assign req_op  = op_type'(req_tuser[OP_W-1:0]);
   assign req_sel = req_tuser[OP_W +: SEL_W];
   assign req_ok  = (req_op inside {OP_SET, OP_CLEAR, OP_RESET}) &&
                    (req_sel inside {MAP_DATA, MAP_INDEX, MAP_LOB});
   assign req_fire  = req_tvalid && req_tready;
   assign word_addr = base_ff + MA_W'(word_ff);
   assign walk_done = (word_ff == last_word_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and control strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            mem_wr_en = 1'b1;
            if (clr_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!req_ok) state_in = ST_OUTPUT;
               else if (req_op == OP_RESET) state_in = ST_READ;
               else state_in = ST_CALC_SHIFT;
            end
         end
         ST_CALC_SHIFT: state_in = ST_CALC_ALIGN;
         ST_CALC_ALIGN: state_in = ST_CALC_COUNT;
         ST_CALC_COUNT: state_in = ST_CALC_END;
         ST_CALC_END:   state_in = ST_RANGE;
         ST_RANGE: begin
            state_in = (bstart_ff < hi_ff) ? ST_READ : ST_OUTPUT;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            mem_wr_en = 1'b1;
            state_in  = walk_done ? ST_OUTPUT : ST_READ;
         end
         ST_OUTPUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (state_ff == ST_INIT) begin
         clr_addr_ff <= clr_addr_ff + MA_W'(1);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         data_shift_ff <= DATA_SHIFT_RST;
         lob_shift_ff  <= LOB_SHIFT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DATA_PAGE_SHIFT: data_shift_ff <= csr_data;
            CSR_LOB_PAGE_SHIFT:  lob_shift_ff  <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // range arithmetic terms
   assign rem     = offset_ff & BLK_MASK;
   assign cut     = BLK_SIZE - rem;
   assign bstart0 = BLK_W'(offset_ff >> BLOCK_SHIFT);
   assign bend    = bstart_ff + cnt_ff;
   assign astart  = BYTE_W'(bstart_ff) << BLOCK_SHIFT;
   assign acnt    = BYTE_W'(cnt_ff) << BLOCK_SHIFT;
   assign hi_last = hi_ff - BLK_W'(1);
   assign lo_idx  = bstart_ff[IDX_W-1:0];
   assign hi_idx  = hi_last[IDX_W-1:0];

   // word mask and modified word
   assign lo_part  = (word_ff == first_word_ff) ? (ONES << lo_off_ff) : ONES;
   assign hi_part  = (word_ff == last_word_ff) ?
                     (ONES >> (WOFF_W'(WORD_BITS - 1) - hi_off_ff)) : ONES;
   assign new_word = set_bits_ff ? (mem_rd_data | mask_ff) : (mem_rd_data & ~mask_ff);

   // request datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_ff        <= req_op;
               req_ok_ff    <= req_ok;
               set_bits_ff  <= (req_op == OP_SET);
               start_ff     <= req_tdata[PAGE_W-1:0];
               num_ff       <= req_tdata[PAGE_W +: PAGE_W];
               ps_ff        <= (req_sel == MAP_LOB) ?
                               clamp_shift(lob_shift_ff, LOB_SHIFT_MIN, LOB_SHIFT_MAX) :
                               clamp_shift(data_shift_ff, DATA_SHIFT_MIN, DATA_SHIFT_MAX);
               base_ff      <= MA_W'(req_sel) * MA_W'(WORDS);
               chg_ff       <= 1'b0;
               res_start_ff <= '0;
               res_num_ff   <= '0;
               res_boff_ff  <= '0;
               res_blen_ff  <= '0;
               // whole-map reset walks every word with a full mask
               word_ff       <= '0;
               first_word_ff <= '0;
               last_word_ff  <= LAST_WORD;
               lo_off_ff     <= '0;
               hi_off_ff     <= WOFF_W'(WORD_BITS - 1);
            end
         end
         ST_CALC_SHIFT: begin
            offset_ff <= BYTE_W'(start_ff) << ps_ff;
            length_ff <= BYTE_W'(num_ff) << ps_ff;
         end
         ST_CALC_ALIGN: begin
            if (op_ff == OP_SET) begin
               // shrink inward to whole blocks
               if (rem != '0) begin
                  length_ff <= (length_ff > cut) ? (length_ff - cut) : '0;
                  bstart_ff <= bstart0 + BLK_W'(1);
               end else begin
                  bstart_ff <= bstart0;
               end
            end else begin
               // widen outward to whole blocks
               length_ff <= length_ff + rem;
               bstart_ff <= bstart0;
            end
         end
         ST_CALC_COUNT: begin
            cnt_ff <= BLK_W'(length_ff >> BLOCK_SHIFT) +
                      BLK_W'(op_ff == OP_CLEAR && (length_ff & BLK_MASK) != '0);
         end
         ST_CALC_END: begin
            hi_ff        <= (bend > BLK_CAP) ? BLK_CAP : bend;
            res_start_ff <= PAGE_W'(astart >> ps_ff);
            res_num_ff   <= PAGE_W'(acnt >> ps_ff);
            res_boff_ff  <= astart[BYTE_OUT_W-1:0];
            res_blen_ff  <= acnt[BYTE_OUT_W-1:0];
         end
         ST_RANGE: begin
            word_ff       <= WORD_W'(lo_idx >> WOFF_W);
            first_word_ff <= WORD_W'(lo_idx >> WOFF_W);
            last_word_ff  <= WORD_W'(hi_idx >> WOFF_W);
            lo_off_ff     <= lo_idx[WOFF_W-1:0];
            hi_off_ff     <= hi_idx[WOFF_W-1:0];
         end
         ST_READ: begin
            mask_ff <= lo_part & hi_part;
         end
         ST_WRITE: begin
            if (new_word != mem_rd_data) chg_ff <= 1'b1;
            if (!walk_done) word_ff <= word_ff + WORD_W'(1);
         end
         default: ;
      endcase
   end

   // memory ports
   assign mem_wr_addr = (state_ff == ST_INIT) ? clr_addr_ff : word_addr;
   assign mem_wr_data = (state_ff == ST_INIT) ? '0 : new_word;

   hbbrm_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (MA_W),
      .DATA_W (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (word_addr),
      .rd_data (mem_rd_data)
   );

   // byte fields only meaningful for set, or for a clear that changed a bit
   assign offset_valid = req_ok_ff &&
                         ((op_ff == OP_SET) || (op_ff == OP_CLEAR && chg_ff));

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {4'b0,
                          offset_valid ? res_blen_ff : {BYTE_OUT_W{1'b0}},
                          offset_valid ? res_boff_ff : {BYTE_OUT_W{1'b0}},
                          res_num_ff,
                          res_start_ff};
         rsp_tuser_ff <= {offset_valid, chg_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ design/hbbrm_checker.sv @@
// Port-level checker for the hole block bitmap range marker, bound to the top.
// Depends on hbbrm_pkg and on the port list of hole_block_bitmap_range_marker.
module hbbrm_assertions (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hbbrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [hbbrm_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request at a time: busy right after a request transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // byte fields are zero unless offset_valid
   a_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[163:62] == '0)
      else $error("byte fields set without offset_valid");

   // reset drops the result and holds off requests for the clearing pass
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("channels active right after reset");

endmodule

bind hole_block_bitmap_range_marker hbbrm_assertions u_hbbrm_assertions (.*);
